>>> src/itrn_pkg.sv
// itrn_pkg: shared types, tables and helpers for the integer to roman numeral unit
// no dependencies; imported by itrn_ctrl, itrn_datapath and the top level
`default_nettype none

package itrn_pkg;

    localparam int unsigned VALUE_W   = 12;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned NUM_WEIGHTS = 13;
    localparam int unsigned IDX_W     = 4;
    localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [IDX_W-1:0]   t_idx;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERROR,
        ST_LEAD,
        ST_TRAIL
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic emit_err;
        logic emit_lead;
        logic emit_trail;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic range_ok;
        logic two_char;
        logic lead_last;
        logic rem_zero;
    } t_status;

    // weight of each table entry, largest first
    function automatic t_value weight_of(input t_idx idx);
        t_value w;
        unique case (idx)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            4'd12:   w = 12'd1;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    // first character of each symbol
    function automatic t_char lead_of(input t_idx idx);
        t_char c;
        unique case (idx)
            4'd0:                      c = 8'h4D; // M
            4'd1, 4'd3, 4'd4:          c = 8'h43; // C
            4'd2:                      c = 8'h44; // D
            4'd5, 4'd7, 4'd8:          c = 8'h58; // X
            4'd6:                      c = 8'h4C; // L
            4'd10:                     c = 8'h56; // V
            4'd9, 4'd11, 4'd12:        c = 8'h49; // I
            default:                   c = 8'h49;
        endcase
        return c;
    endfunction

    // second character of the subtractive pairs
    function automatic t_char trail_of(input t_idx idx);
        t_char c;
        unique case (idx)
            4'd1:    c = 8'h4D; // M
            4'd3:    c = 8'h44; // D
            4'd5:    c = 8'h43; // C
            4'd7:    c = 8'h4C; // L
            4'd9:    c = 8'h58; // X
            4'd11:   c = 8'h56; // V
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // subtractive pairs sit at the odd entries
    function automatic logic is_pair(input t_idx idx);
        return idx[0];
    endfunction

    // entry with the largest weight not above rem
    function automatic t_idx pick_index(input t_value rem);
        t_idx sel;
        sel = t_idx'(NUM_WEIGHTS - 1);
        for (int i = NUM_WEIGHTS - 1; i >= 0; i--) begin
            if (rem >= weight_of(t_idx'(i))) begin
                sel = t_idx'(i);
            end
        end
        return sel;
    endfunction

endpackage

`default_nettype wire

>>> src/itrn_ctrl.sv
// itrn_ctrl: sequencing state machine for the roman numeral unit
// depends on itrn_pkg; drives itrn_datapath through t_cmd, reads t_status
`default_nettype none

module itrn_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  itrn_pkg::t_status     i_status,
    output itrn_pkg::t_cmd        o_cmd,
    output logic                  o_busy
);
    import itrn_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = i_status.range_ok ? ST_LEAD : ST_ERROR;
                end
            end
            ST_ERROR: begin
                n_state = ST_IDLE;
            end
            ST_LEAD: begin
                if (i_status.two_char) begin
                    n_state = ST_TRAIL;
                end else if (i_status.lead_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TRAIL: begin
                n_state = i_status.rem_zero ? ST_IDLE : ST_LEAD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_ERROR: o_cmd.emit_err   = 1'b1;
            ST_LEAD:  o_cmd.emit_lead  = 1'b1;
            ST_TRAIL: o_cmd.emit_trail = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

>>> src/itrn_datapath.sv
// itrn_datapath: remainder register, symbol selection and result registers
// depends on itrn_pkg; commanded by itrn_ctrl
`default_nettype none

module itrn_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  itrn_pkg::t_value           i_value,
    input  itrn_pkg::t_cmd             i_cmd,
    output itrn_pkg::t_status          o_status,
    output logic                       o_strobe,
    output itrn_pkg::t_char            o_symbol_char,
    output logic                       o_last_char,
    output logic                       o_range_error
);
    import itrn_pkg::*;

    t_value r_rem;
    t_idx   r_idx;
    logic   r_strobe;
    t_char  r_char;
    logic   r_last;
    logic   r_err;

    t_idx   sel;
    t_value rem_next;

    // largest symbol that fits the remainder
    assign sel      = pick_index(r_rem);
    assign rem_next = r_rem - weight_of(sel);

    // status to the controller
    always_comb begin
        o_status.range_ok  = (i_value != '0) && (i_value <= MAX_VALID);
        o_status.two_char  = is_pair(sel);
        o_status.lead_last = !is_pair(sel) && (rem_next == '0);
        o_status.rem_zero  = (r_rem == '0);
    end

    // remainder and pending pair index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= i_value;
        end else if (i_cmd.emit_lead) begin
            r_rem <= rem_next;
            r_idx <= sel;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_err | i_cmd.emit_lead | i_cmd.emit_trail;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_err) begin
            r_char <= '0;
            r_last <= 1'b1;
            r_err  <= 1'b1;
        end else if (i_cmd.emit_lead) begin
            r_char <= lead_of(sel);
            r_last <= !is_pair(sel) && (rem_next == '0);
            r_err  <= 1'b0;
        end else if (i_cmd.emit_trail) begin
            r_char <= trail_of(r_idx);
            r_last <= (r_rem == '0);
            r_err  <= 1'b0;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_symbol_char = r_char;
    assign o_last_char   = r_last;
    assign o_range_error = r_err;

endmodule

`default_nettype wire

>>> src/integer_to_roman_numeral_unit.sv
// integer_to_roman_numeral_unit: converts 1..3999 to roman numeral characters
// start loads the state and remainder registers, then the first character is registered
// a numeral has at most 15 characters; a new start is taken only in idle, once the last
//   character or the range error has left; while busy one character leaves per cycle
// results leave on a one-cycle strobe; the receiver cannot stall
// reset: synchronous active low, returns to idle and drops the strobe
`default_nettype none

module integer_to_roman_numeral_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  itrn_pkg::t_value       i_value,
    output logic                   o_strobe,
    output itrn_pkg::t_char        o_symbol_char,
    output logic                   o_last_char,
    output logic                   o_range_error
);
    import itrn_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    itrn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // remainder and output registers
    itrn_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_strobe      (o_strobe),
        .o_symbol_char (o_symbol_char),
        .o_last_char   (o_last_char),
        .o_range_error (o_range_error)
    );

endmodule

`default_nettype wire
